/* src/b64d_pkg.sv */
// Shared types, constants and the character classifier of the Base64 stream decoder.
package b64d_pkg;

	// Queue between front and back
	localparam int FifoDepth = 4;
	localparam int FifoPtrW  = $clog2(FifoDepth);
	localparam int FifoLvlW  = $clog2(FifoDepth + 1);

	// Output capacity after reset
	localparam logic [15:0] CapacityReset = 16'hFFFF;

	// Sextet values of the two punctuation symbols
	localparam logic [5:0] SextetPlus  = 6'd62;
	localparam logic [5:0] SextetSlash = 6'd63;

	// Alphabet characters
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperZ = 8'h5A;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChLowerZ = 8'h7A;
	localparam logic [7:0] ChDigit0 = 8'h30;
	localparam logic [7:0] ChDigit9 = 8'h39;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChSlash  = 8'h2F;

	// Position within a group of four sextets
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2,
		PH_FOURTH = 2'd3
	} phase_t;

	// Classified item held in the queue
	typedef struct packed {
		logic       sym;
		logic       start;
		logic [5:0] sextet;
	} item_t;

	typedef struct packed {
		logic                full;
		logic                empty;
		logic [FifoLvlW-1:0] level;
	} fifo_status_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] count;
	} back_status_t;

	// Map a raw byte onto its sextet; sym is low for anything outside the alphabet
	function automatic item_t classify(input logic [7:0] ch, input logic start);
		item_t r;
		r.start  = start;
		r.sym    = 1'b1;
		r.sextet = '0;
		if (ch >= ChUpperA && ch <= ChUpperZ) begin
			r.sextet = 6'(ch - ChUpperA);
		end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
			r.sextet = 6'(ch - ChLowerA + 8'd26);
		end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
			r.sextet = 6'(ch - ChDigit0 + 8'd52);
		end else if (ch == ChPlus) begin
			r.sextet = SextetPlus;
		end else if (ch == ChSlash) begin
			r.sextet = SextetSlash;
		end else begin
			r.sym = 1'b0;
		end
		return r;
	endfunction

endpackage

/* src/b64d_if.sv */
// Handshake channels of the Base64 stream decoder: text characters in, decoded bytes out.
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       start_of_message;

	modport source (output valid, output character, output start_of_message, input ready);
	modport sink   (input valid, input character, input start_of_message, output ready);
endinterface

interface b64d_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] byte_position;

	modport source (output valid, output data_byte, output byte_position, input ready);
	modport sink   (input valid, input data_byte, input byte_position, output ready);
endinterface

/* src/base64_stream_decoder_unit.sv */
// Top level of the Base64 stream decoder: front end, item queue, back end and capacity register.
//
// Decodes a Base64 text stream (A-Z, a-z, 0-9, '+', '/') one character per item and emits
// each decoded byte with its position in the message. Any other byte, '=' and 128..255
// included, is dropped; a start flag on it still opens a new message. A character is
// accepted in the same cycle it is offered whenever the four-entry queue has room, so the
// block sustains one character per clock; a decoded byte goes through the queue, written when
// its character is accepted, and the output register, written when the back end pops it.
// The output register decouples the sink: a stalled sink fills the queue, then drops ready.
// Bytes beyond the capacity register are not emitted; write the capacity only while idle.
module base64_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        capacity_we,
	input  logic [15:0] capacity_wdata,
	b64d_char_if.sink   text,
	b64d_byte_if.source decoded
);

	logic [15:0]            capacity_q;
	logic                   push;
	logic                   pop;
	b64d_pkg::item_t        push_item;
	b64d_pkg::item_t        pop_item;
	b64d_pkg::fifo_status_t fifo_st;
	b64d_pkg::back_status_t back_st;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= b64d_pkg::CapacityReset;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	b64d_front u_front (
		.text      (text),
		.fifo_st   (fifo_st),
		.push      (push),
		.push_item (push_item)
	);

	b64d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (fifo_st)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.fifo_st  (fifo_st),
		.item     (pop_item),
		.pop      (pop),
		.status   (back_st),
		.decoded  (decoded)
	);

	// Queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.level <= b64d_pkg::FifoLvlW'(b64d_pkg::FifoDepth))
		else $error("item queue level above depth");

	// No pop from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.empty |-> !pop)
		else $error("pop from empty item queue");

	// Fourth sextet of a group closes it
	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_item.sym && !pop_item.start && back_st.phase == b64d_pkg::PH_FOURTH)
		|=> back_st.phase == b64d_pkg::PH_FIRST)
		else $error("sextet phase did not wrap after fourth sextet");

	// A start item with an alphabet character leaves phase at the second sextet
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_item.sym && pop_item.start) |=> back_st.phase == b64d_pkg::PH_SECOND)
		else $error("start of message did not restart sextet grouping");

endmodule

/* src/b64d_front.sv */
// Front end: accepts characters, classifies them and queues those that matter.
module b64d_front (
	b64d_char_if.sink              text,
	input  b64d_pkg::fifo_status_t fifo_st,
	output logic                   push,
	output b64d_pkg::item_t        push_item
);

	b64d_pkg::item_t cls;

	// Alphabet lookup
	always_comb begin
		cls = b64d_pkg::classify(text.character, text.start_of_message);
	end

	// Take an item whenever the queue has room; skipped characters only
	// enter when they carry a start flag
	assign text.ready = !fifo_st.full;
	assign push       = text.valid && text.ready && (cls.sym || cls.start);
	assign push_item  = cls;

endmodule

/* src/b64d_fifo.sv */
// Short queue of classified items between front and back.
module b64d_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  b64d_pkg::item_t        push_item,
	input  logic                   pop,
	output b64d_pkg::item_t        pop_item,
	output b64d_pkg::fifo_status_t status
);

	b64d_pkg::item_t                mem_q [b64d_pkg::FifoDepth];
	logic [b64d_pkg::FifoPtrW-1:0]  wr_ptr_q;
	logic [b64d_pkg::FifoPtrW-1:0]  rd_ptr_q;
	logic [b64d_pkg::FifoLvlW-1:0]  level_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign pop_item     = mem_q[rd_ptr_q];
	assign status.level = level_q;
	assign status.full  = (level_q == b64d_pkg::FifoLvlW'(b64d_pkg::FifoDepth));
	assign status.empty = (level_q == '0);

endmodule

/* src/b64d_back.sv */
// Back end: sextet grouping, byte assembly, capacity limit and the output register.
module b64d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [15:0]            capacity,
	input  b64d_pkg::fifo_status_t fifo_st,
	input  b64d_pkg::item_t        item,
	output logic                   pop,
	output b64d_pkg::back_status_t status,
	b64d_byte_if.source            decoded
);

	b64d_pkg::phase_t phase_q;
	logic [5:0]       prev_q;
	logic [15:0]      count_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [15:0]      out_pos_q;

	b64d_pkg::phase_t phase_eff;
	logic [5:0]       prev_eff;
	logic [15:0]      count_eff;
	logic [7:0]       byte_val;
	logic             have_byte;
	logic             emit;

	// Take the next item when the output register is free or being drained
	assign pop = !fifo_st.empty && (!out_valid_q || decoded.ready);

	// State as seen by this item, after an optional start clear
	always_comb begin
		phase_eff = item.start ? b64d_pkg::PH_FIRST : phase_q;
		prev_eff  = item.start ? 6'd0 : prev_q;
		count_eff = item.start ? 16'd0 : count_q;
	end

	// Byte assembly from previous and current sextet
	always_comb begin
		byte_val  = '0;
		have_byte = 1'b1;
		unique case (phase_eff)
			b64d_pkg::PH_FIRST: begin
				have_byte = 1'b0;
			end
			b64d_pkg::PH_SECOND: begin
				byte_val = {prev_eff, item.sextet[5:4]};
			end
			b64d_pkg::PH_THIRD: begin
				byte_val = {prev_eff[3:0], item.sextet[5:2]};
			end
			b64d_pkg::PH_FOURTH: begin
				byte_val = {prev_eff[1:0], item.sextet};
			end
			default: begin
				have_byte = 1'b0;
			end
		endcase
	end

	assign emit = pop && item.sym && have_byte && (count_eff < capacity);

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64d_pkg::PH_FIRST;
			prev_q  <= '0;
			count_q <= '0;
		end else if (pop) begin
			if (item.sym) begin
				phase_q <= b64d_pkg::phase_t'(phase_eff + 2'd1);
				prev_q  <= item.sextet;
			end else begin
				phase_q <= phase_eff;
				prev_q  <= prev_eff;
			end
			count_q <= emit ? count_eff + 16'd1 : count_eff;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_val;
			out_pos_q  <= count_eff;
		end
	end

	assign decoded.valid         = out_valid_q;
	assign decoded.data_byte     = out_byte_q;
	assign decoded.byte_position = out_pos_q;

	assign status.phase = phase_q;
	assign status.count = count_q;

endmodule
